// ===== design/vaab_pkg.sv =====
// Shared types and constants for the voice allocator / envelope bank.
package vaab_pkg;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_ON     = 3'd1,
    ACT_OFF    = 3'd2,
    ACT_LD_ATK = 3'd3,
    ACT_LD_DCY = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_DECAY   = 2'd1;
  localparam logic [1:0] CFG_RELEASE = 2'd2;
  localparam logic [1:0] CFG_SUSTAIN = 2'd3;

  localparam logic [15:0] ATK_RST = 16'd3023;
  localparam logic [16:0] DCY_RST = 17'd10078;
  localparam logic [16:0] REL_RST = 17'd9826;
  localparam logic [11:0] SUS_RST = 12'd4095;

  localparam logic [12:0] LEVEL_MAX = 13'd8191;
  localparam logic [11:0] IDX_MAX   = 12'd4095;
  localparam logic [11:0] SUS_FULL  = 12'd4095;
  localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
  localparam logic [4:0]  DIV_LAST  = 5'd16;

  typedef struct packed {
    logic acc;
    logic v_load;
    logic div_step;
    logic tbl_rd;
    logic mul;
    logic wb;
    logic emit_tick;
    logic idx_inc;
    logic scan_on;
    logic pick;
    logic on_commit;
    logic off_step;
    logic off_emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic idx_last;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== design/vaab_if.sv =====
// Input and result channel interfaces.
interface vaab_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [6:0]  note;
  logic [11:0] table_addr;
  logic [12:0] table_data;
  modport source(output valid, action, note, table_addr, table_data, input ready);
  modport sink(input valid, action, note, table_addr, table_data, output ready);
endinterface

interface vaab_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  voice;
  logic [2:0]  phase;
  logic [12:0] level;
  logic [4:0]  released_count;
  logic        last;
  modport source(output valid, voice, phase, level, released_count, last, input ready);
  modport sink(input valid, voice, phase, level, released_count, last, output ready);
endinterface

// ===== design/vaab_ctrl.sv =====
// Sequencer for ticks, note-on scan and note-off scan.
module vaab_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_action,
  output logic                in_ready,
  input  vaab_pkg::ctl_sts_t  sts,
  output vaab_pkg::ctl_cmd_t  cmd
);
  import vaab_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_LOAD = 12'b000000000010,
    S_DIV  = 12'b000000000100,
    S_TBL  = 12'b000000001000,
    S_MUL  = 12'b000000010000,
    S_WB   = 12'b000000100000,
    S_TOUT = 12'b000001000000,
    S_SON  = 12'b000010000000,
    S_PICK = 12'b000100000000,
    S_OOUT = 12'b001000000000,
    S_SOFF = 12'b010000000000,
    S_FOUT = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          case (action_t'(in_action))
            ACT_TICK: state_nxt = S_LOAD;
            ACT_ON:   state_nxt = S_SON;
            ACT_OFF:  state_nxt = S_SOFF;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.v_load = 1'b1;
        state_nxt  = sts.need_div ? S_DIV : S_TOUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_TBL;
      end
      S_TBL: begin
        cmd.tbl_rd = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_TOUT;
      end
      S_TOUT: begin
        if (sts.out_free) begin
          cmd.emit_tick = 1'b1;
          if (sts.idx_last) state_nxt = S_IDLE;
          else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_LOAD;
          end
        end
      end
      S_SON: begin
        cmd.scan_on = 1'b1;
        if (sts.idx_last) state_nxt = S_PICK;
        else cmd.idx_inc = 1'b1;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_OOUT;
      end
      S_OOUT: begin
        if (sts.out_free) begin
          cmd.on_commit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SOFF: begin
        cmd.off_step = 1'b1;
        if (sts.idx_last) state_nxt = S_FOUT;
        else cmd.idx_inc = 1'b1;
      end
      S_FOUT: begin
        if (sts.out_free) begin
          cmd.off_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/vaab_dp.sv =====
// Voice state, curve tables, serial divider, level math and result register.
module vaab_dp #(
  parameter int VOICES       = 20,
  parameter int TICKS_PER_MS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vaab_pkg::ctl_cmd_t  cmd,
  output vaab_pkg::ctl_sts_t  sts,
  input  logic [2:0]          in_action,
  input  logic [6:0]          in_note,
  input  logic [11:0]         in_table_addr,
  input  logic [12:0]         in_table_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [16:0]         cfg_wdata,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [4:0]          out_voice,
  output logic [2:0]          out_phase,
  output logic [12:0]         out_level,
  output logic [4:0]          out_released_count,
  output logic                out_last
);
  import vaab_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW-1:0] IDX_LAST = VW'(VOICES - 1);

  // configuration
  logic [15:0] atk_cnt_r;
  logic [16:0] dcy_cnt_r, rel_cnt_r;
  logic [11:0] sus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atk_cnt_r <= ATK_RST;
      dcy_cnt_r <= DCY_RST;
      rel_cnt_r <= REL_RST;
      sus_r     <= SUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ATTACK:  atk_cnt_r <= cfg_wdata[15:0];
        CFG_DECAY:   dcy_cnt_r <= cfg_wdata;
        CFG_RELEASE: rel_cnt_r <= cfg_wdata;
        CFG_SUSTAIN: sus_r     <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // voice bank
  phase_t      ph_r     [VOICES];
  logic [6:0]  note_r   [VOICES];
  logic [16:0] pcnt_r   [VOICES];
  logic [12:0] lvl_r    [VOICES];
  logic [12:0] rstart_r [VOICES];
  logic [31:0] stime_r  [VOICES];

  logic [VW-1:0] idx_r;
  logic [5:0]    tick_ms_r, tick_ms_nxt;
  logic [31:0]   ms_r;
  logic [6:0]    cur_note_r;

  phase_t      cur_ph;
  logic [12:0] cur_lvl;
  logic [16:0] cur_len;
  logic [17:0] cnt1;
  logic        active, done;
  logic [4:0]  dvs;

  assign cur_ph  = ph_r[idx_r];
  assign cur_lvl = lvl_r[idx_r];

  always_comb begin
    case (cur_ph)
      PH_ATTACK:  cur_len = {1'b0, atk_cnt_r};
      PH_DECAY:   cur_len = dcy_cnt_r;
      PH_RELEASE: cur_len = rel_cnt_r;
      default:    cur_len = '0;
    endcase
  end

  assign cnt1   = {1'b0, pcnt_r[idx_r]} + 18'd1;
  assign active = (cur_ph == PH_ATTACK) || (cur_ph == PH_DECAY) || (cur_ph == PH_RELEASE);
  assign done   = cnt1 >= {1'b0, cur_len};
  assign dvs    = (cur_len[16:12] == 5'd0) ? 5'd1 : cur_len[16:12];

  // work registers for one voice update
  phase_t      w_ph_r;
  logic [16:0] w_cnt_r;
  logic [16:0] dvd_r, quo_r;
  logic [5:0]  rem_r;
  logic [4:0]  dvs_r, dstep_r;
  logic [5:0]  rem_sh;
  logic        rem_ge;
  logic [11:0] tidx;
  logic [12:0] atk_rd_r, dcy_rd_r;
  logic [25:0] prod_r;
  logic [12:0] factor;
  logic [14:0] lvl_sum;
  logic [12:0] new_lvl;

  assign rem_sh = {rem_r[4:0], dvd_r[16]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};
  assign tidx   = (quo_r > 17'(IDX_MAX)) ? IDX_MAX : quo_r[11:0];
  assign factor = (w_ph_r == PH_DECAY) ? 13'(SUS_FULL - sus_r) : rstart_r[idx_r];
  assign lvl_sum = (w_ph_r == PH_DECAY) ? 15'(prod_r[25:12]) + 15'(sus_r)
                                        : 15'(prod_r[25:12]);

  always_comb begin
    if (w_ph_r == PH_ATTACK)          new_lvl = atk_rd_r;
    else if (lvl_sum > 15'(LEVEL_MAX)) new_lvl = LEVEL_MAX;
    else                               new_lvl = lvl_sum[12:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.v_load) begin
      w_ph_r  <= cur_ph;
      w_cnt_r <= cnt1[16:0];
      dvd_r   <= cnt1[16:0];
      quo_r   <= '0;
      rem_r   <= '0;
      dvs_r   <= dvs;
      dstep_r <= '0;
    end else if (cmd.div_step) begin
      rem_r   <= rem_ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_r   <= {quo_r[15:0], rem_ge};
      dvd_r   <= {dvd_r[15:0], 1'b0};
      dstep_r <= dstep_r + 5'd1;
    end
    if (cmd.mul) prod_r <= dcy_rd_r * factor;
  end

  // curve tables
  logic [12:0] atk_mem [4096];
  logic [12:0] dcy_mem [4096];
  logic        acc_ld_atk, acc_ld_dcy;

  assign acc_ld_atk = cmd.acc && (action_t'(in_action) == ACT_LD_ATK);
  assign acc_ld_dcy = cmd.acc && (action_t'(in_action) == ACT_LD_DCY);

  always_ff @(posedge clk) begin
    if (acc_ld_atk) atk_mem[in_table_addr] <= in_table_data;
    if (cmd.tbl_rd) atk_rd_r <= atk_mem[tidx];
  end

  always_ff @(posedge clk) begin
    if (acc_ld_dcy) dcy_mem[in_table_addr] <= in_table_data;
    if (cmd.tbl_rd) dcy_rd_r <= dcy_mem[tidx];
  end

  // note-on candidates
  logic          idle_hit_r, same_hit_r, rel_hit_r;
  logic [VW-1:0] idle_slot_r, same_slot_r, rel_slot_r, time_slot_r;
  logic [12:0]   rel_best_r;
  logic [31:0]   time_best_r;
  logic [VW:0]   rel_count_r;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      idle_hit_r  <= 1'b0;
      same_hit_r  <= 1'b0;
      rel_hit_r   <= 1'b0;
      time_best_r <= TIME_MAX;
      time_slot_r <= '0;
      rel_count_r <= '0;
      cur_note_r  <= in_note;
    end else if (cmd.scan_on) begin
      if (cur_ph == PH_IDLE && !idle_hit_r) begin
        idle_hit_r  <= 1'b1;
        idle_slot_r <= idx_r;
      end
      if (note_r[idx_r] == cur_note_r && !same_hit_r) begin
        same_hit_r  <= 1'b1;
        same_slot_r <= idx_r;
      end
      if (cur_ph == PH_RELEASE && (!rel_hit_r || cur_lvl < rel_best_r)) begin
        rel_hit_r  <= 1'b1;
        rel_best_r <= cur_lvl;
        rel_slot_r <= idx_r;
      end
      if (stime_r[idx_r] < time_best_r) begin
        time_best_r <= stime_r[idx_r];
        time_slot_r <= idx_r;
      end
    end else if (cmd.off_step && note_r[idx_r] == cur_note_r &&
                 cur_ph != PH_IDLE && cur_ph != PH_RELEASE) begin
      rel_count_r <= rel_count_r + (VW+1)'(1);
    end
  end

  // voice index and millisecond timer
  always_comb begin
    tick_ms_nxt = tick_ms_r + 6'd1;
    if (tick_ms_nxt >= 6'(TICKS_PER_MS)) tick_ms_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_ms_r <= '0;
      ms_r      <= '0;
      idx_r     <= '0;
    end else begin
      if (cmd.acc) begin
        idx_r <= '0;
        if (action_t'(in_action) == ACT_TICK) begin
          tick_ms_r <= tick_ms_nxt;
          if (tick_ms_nxt == 6'd0) ms_r <= ms_r + 32'd1;
        end
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + VW'(1);
      end else if (cmd.pick) begin
        idx_r <= idle_hit_r ? idle_slot_r :
                 same_hit_r ? same_slot_r :
                 rel_hit_r  ? rel_slot_r  : time_slot_r;
      end
    end
  end

  // voice bank updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        ph_r[i]  <= PH_IDLE;
        lvl_r[i] <= '0;
      end
    end else begin
      if (cmd.v_load && active && done) begin
        pcnt_r[idx_r] <= '0;
        case (cur_ph)
          PH_ATTACK: ph_r[idx_r] <= PH_DECAY;
          PH_DECAY:  ph_r[idx_r] <= PH_SUSTAIN;
          default: begin
            ph_r[idx_r]  <= PH_IDLE;
            lvl_r[idx_r] <= '0;
          end
        endcase
      end else if (cmd.v_load && cur_ph == PH_SUSTAIN) begin
        lvl_r[idx_r] <= 13'(sus_r);
      end
      if (cmd.wb) begin
        pcnt_r[idx_r] <= w_cnt_r;
        lvl_r[idx_r]  <= new_lvl;
      end
      if (cmd.on_commit) begin
        note_r[idx_r]  <= cur_note_r;
        stime_r[idx_r] <= ms_r;
        pcnt_r[idx_r]  <= '0;
        ph_r[idx_r]    <= PH_ATTACK;
      end
      if (cmd.off_step && note_r[idx_r] == cur_note_r &&
          cur_ph != PH_IDLE && cur_ph != PH_RELEASE) begin
        rstart_r[idx_r] <= cur_lvl;
        pcnt_r[idx_r]   <= '0;
        ph_r[idx_r]     <= PH_RELEASE;
      end
    end
  end

  // result register
  logic out_valid_r;
  logic emit;
  logic [4:0]  out_voice_r, out_rel_r;
  logic [2:0]  out_phase_r;
  logic [12:0] out_level_r;
  logic        out_last_r;

  assign emit = cmd.emit_tick || cmd.on_commit || cmd.off_emit;

  always_ff @(posedge clk) begin
    if (!rst_n)                out_valid_r <= 1'b0;
    else if (emit)             out_valid_r <= 1'b1;
    else if (out_ready)        out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_tick) begin
      out_voice_r <= 5'(idx_r);
      out_phase_r <= cur_ph;
      out_level_r <= cur_lvl;
      out_rel_r   <= '0;
      out_last_r  <= idx_r == IDX_LAST;
    end else if (cmd.on_commit) begin
      out_voice_r <= 5'(idx_r);
      out_phase_r <= PH_ATTACK;
      out_level_r <= cur_lvl;
      out_rel_r   <= '0;
      out_last_r  <= 1'b1;
    end else if (cmd.off_emit) begin
      out_voice_r <= '0;
      out_phase_r <= PH_IDLE;
      out_level_r <= '0;
      out_rel_r   <= 5'(rel_count_r);
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_voice          = out_voice_r;
  assign out_phase          = out_phase_r;
  assign out_level          = out_level_r;
  assign out_released_count = out_rel_r;
  assign out_last           = out_last_r;

  assign sts.need_div = active && !done;
  assign sts.div_last = dstep_r == DIV_LAST;
  assign sts.idx_last = idx_r == IDX_LAST;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// ===== design/voice_allocator_adsr_bank.sv =====
// Tick: VOICES results; an active voice not ending its phase runs the serial divider that
// forms the curve index, then table read, multiply and write-back, which idle or sustaining
// voices skip. Note-on: one voice compared per cycle. Note-off: a scan of all voices.
// A word waiting at the output does not block the next input.
// Reset (synchronous, rst_n low): all voices idle at level 0, timers zero, registers at
// defaults; curve tables are not cleared and must be loaded before use.
module voice_allocator_adsr_bank #(
  parameter int VOICES       = 20,
  parameter int TICKS_PER_MS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  vaab_in_if.sink            in_ch,
  vaab_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [16:0]        cfg_wdata
);
  import vaab_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  vaab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vaab_dp #(
    .VOICES       (VOICES),
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_ch.action),
    .in_note            (in_ch.note),
    .in_table_addr      (in_ch.table_addr),
    .in_table_data      (in_ch.table_data),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_voice          (out_ch.voice),
    .out_phase          (out_ch.phase),
    .out_level          (out_ch.level),
    .out_released_count (out_ch.released_count),
    .out_last           (out_ch.last)
  );

endmodule

// ===== design/vaab_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module vaab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_voice,
  input logic [2:0]  out_phase,
  input logic [12:0] out_level,
  input logic [4:0]  out_released_count,
  input logic        out_last
);
  import vaab_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_voice) && $stable(out_level)
      && $stable(out_phase) && $stable(out_last))
    else $error("result word changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase <= PH_RELEASE)
    else $error("phase code out of range");

  // only note-off words carry a release count
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_released_count != 5'd0 |->
      out_last && out_voice == 5'd0 && out_phase == PH_IDLE)
    else $error("release count on a non note-off word");

  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == PH_IDLE |-> out_level == 13'd0)
    else $error("idle voice with nonzero level");

endmodule

bind voice_allocator_adsr_bank vaab_checker u_vaab_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_voice          (out_ch.voice),
  .out_phase          (out_ch.phase),
  .out_level          (out_ch.level),
  .out_released_count (out_ch.released_count),
  .out_last           (out_ch.last)
);
